[src/serpf_pkg.sv]
// shared constants and types for the serial parameter frame parser
package serpf_pkg;

  localparam int unsigned PAYLOAD_LEN = 56;
  localparam int unsigned WORD_LIMIT  = 14;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] TAIL_BYTE  = 8'h02;

  localparam logic [7:0] CMD_READ    = 8'h01;
  localparam logic [7:0] CMD_CAPTURE = 8'h02;
  localparam logic [7:0] CMD_SAVE    = 8'h03;

  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_SAVE = 2'd2;

  // gather counter: four read slots plus the final merge slot
  localparam logic [2:0] GATHER_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_OUT   = 3'b100
  } state_t;

endpackage

[src/serial_param_frame_parser_top.sv]
// serial parameter frame parser: header/command decode, payload capture, word readout
//
// usage: received serial bytes enter on the in_ stream, one byte per word.
// a header 0x55 0xaa followed by a command byte gives a read request (1), starts
// a 56-byte payload capture (2) or gives a save request (3). after a capture
// the next byte is the tail; a tail of 0x02 reads PARAM_COUNT (at most 14)
// little-endian 32-bit words back out of the payload memory.
// results leave on the out_ stream; out_tuser holds the result kind and out_tlast
// marks the final result that a byte caused. bytes that cause nothing give no result.
// timing: a request result appears in the output register in the cycle after
// its byte. each parameter word is gathered through the payload memory read
// port and byte merge register (four reads, one merge) and then held in the
// output register; the next byte is taken only after the whole readout is
// delivered. in_tready is high only while no result is pending.
// reset (synchronous, rst_n low) clears the byte history, the capture flag
// and count, and the sequencer; the payload memory is not cleared since every
// entry is written before a tail can read it.
// when the receiver stalls, the current result holds in the output register
// and the block takes no further input until all results are delivered.
module serial_param_frame_parser_top #(
  parameter int unsigned PARAM_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] param_index, [35:4] param_word, zero pad
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);
  import serpf_pkg::*;

  // number of words a tail emits, capped by what the store holds
  localparam int unsigned WORD_TOTAL = (PARAM_COUNT > WORD_LIMIT) ? WORD_LIMIT : PARAM_COUNT;
  localparam logic [3:0]  LAST_IDX   = 4'(WORD_TOTAL - 1);

  // control state
  state_t      state_r, state_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  prev2_r, prev2_nxt;
  logic        capt_r, capt_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        word_mode_r, word_mode_nxt;
  logic        req_pend_r, req_pend_nxt;
  logic [1:0]  req_kind_r, req_kind_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [2:0]  gcnt_r, gcnt_nxt;

  // payload registers
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_idx_r, out_idx_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;

  // payload memory, one write and one registered read port
  logic [7:0]  mem [PAYLOAD_LEN];
  logic        mem_we;
  logic [5:0]  rd_addr;
  logic [7:0]  rd_q;

  logic        in_acc, out_acc;
  logic [7:0]  rx;
  logic        hdr_seen, store_full, tail_hit, req_now;
  logic [31:0] merged;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {4'b0000, out_word_r, out_idx_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign rx         = in_tdata;
  assign hdr_seen   = (prev2_r == HDR_FIRST) && (prev_r == HDR_SECOND);
  assign store_full = (cnt_r == 6'(PAYLOAD_LEN));
  assign tail_hit   = capt_r && store_full && (rx == TAIL_BYTE);
  assign req_now    = hdr_seen && ((rx == CMD_READ) || (rx == CMD_SAVE));
  assign mem_we     = in_acc && capt_r && !store_full;

  // word address is the slot index times four plus the byte lane
  assign rd_addr    = {widx_r, gcnt_r[1:0]};
  assign merged     = {rd_q, acc_r[31:8]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r] <= rx;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    prev2_nxt     = prev2_r;
    capt_nxt      = capt_r;
    cnt_nxt       = cnt_r;
    word_mode_nxt = word_mode_r;
    req_pend_nxt  = req_pend_r;
    req_kind_nxt  = req_kind_r;
    widx_nxt      = widx_r;
    gcnt_nxt      = gcnt_r;
    acc_nxt       = acc_r;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // capture bookkeeping first, then the command check
          if (capt_r) begin
            if (!store_full) begin
              cnt_nxt = cnt_r + 6'd1;
            end else begin
              cnt_nxt  = '0;
              capt_nxt = 1'b0;
            end
          end
          if (hdr_seen && (rx == CMD_CAPTURE)) begin
            cnt_nxt  = '0;
            capt_nxt = 1'b1;
          end
          prev2_nxt    = prev_r;
          prev_nxt     = rx;
          req_pend_nxt = req_now;
          req_kind_nxt = (rx == CMD_READ) ? KIND_READ : KIND_SAVE;
          if (tail_hit) begin
            word_mode_nxt = 1'b1;
            widx_nxt      = '0;
            gcnt_nxt      = '0;
            state_nxt     = ST_FETCH;
          end else if (req_now) begin
            out_kind_nxt = (rx == CMD_READ) ? KIND_READ : KIND_SAVE;
            out_idx_nxt  = '0;
            out_word_nxt = '0;
            out_last_nxt = 1'b1;
            req_pend_nxt = 1'b0;
            state_nxt    = ST_OUT;
          end
        end
      end
      ST_FETCH: begin
        // read data is registered and arrives in the cycle after its address
        if (gcnt_r != 3'd0) begin
          acc_nxt = merged;
        end
        if (gcnt_r == GATHER_LAST) begin
          out_kind_nxt = KIND_WORD;
          out_idx_nxt  = widx_r;
          out_word_nxt = merged;
          out_last_nxt = (widx_r == LAST_IDX) && !req_pend_r;
          state_nxt    = ST_OUT;
        end else begin
          gcnt_nxt = gcnt_r + 3'd1;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (word_mode_r && (widx_r != LAST_IDX)) begin
            widx_nxt  = widx_r + 4'd1;
            gcnt_nxt  = '0;
            state_nxt = ST_FETCH;
          end else if (word_mode_r && req_pend_r) begin
            // a command that rode on the tail byte goes out after the words
            out_kind_nxt  = req_kind_r;
            out_idx_nxt   = '0;
            out_word_nxt  = '0;
            out_last_nxt  = 1'b1;
            word_mode_nxt = 1'b0;
            req_pend_nxt  = 1'b0;
          end else begin
            word_mode_nxt = 1'b0;
            req_pend_nxt  = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      prev2_r     <= '0;
      capt_r      <= 1'b0;
      cnt_r       <= '0;
      word_mode_r <= 1'b0;
      req_pend_r  <= 1'b0;
      req_kind_r  <= KIND_READ;
      widx_r      <= '0;
      gcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      prev2_r     <= prev2_nxt;
      capt_r      <= capt_nxt;
      cnt_r       <= cnt_nxt;
      word_mode_r <= word_mode_nxt;
      req_pend_r  <= req_pend_nxt;
      req_kind_r  <= req_kind_nxt;
      widx_r      <= widx_nxt;
      gcnt_r      <= gcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  // input is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // capture count stays within the payload memory
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(PAYLOAD_LEN))
    else $error("capture count out of range");

  // parameter words only name slots that exist
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_kind_r == KIND_WORD)) |-> (out_idx_r <= LAST_IDX))
    else $error("parameter index out of range");

  // a delivered final result returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> (state_r == ST_IDLE))
    else $error("no return to idle after last result");
`endif

endmodule
